### hw/rtl/sem_pkg.sv
`default_nettype none

package sem_pkg;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  localparam logic CFG_WIDTH_IDX  = 1'b0;
  localparam logic CFG_HEIGHT_IDX = 1'b1;

  localparam logic [11:0] WIDTH_RESET  = 12'd640;
  localparam logic [15:0] HEIGHT_RESET = 16'd480;

  localparam logic [20:0] SAT_LIMIT = 21'd65280;
  localparam logic [7:0]  EDGE_MAX  = 8'd255;

  typedef struct packed {
    logic       req_type;
    logic [7:0] in_blue;
    logic [7:0] in_green;
    logic [7:0] in_red;
  } sem_in_t;

  typedef struct packed {
    logic [7:0] edge_blue;
    logic [7:0] edge_green;
    logic [7:0] edge_red;
    logic       image_done;
  } sem_out_t;

  // Window columns indexed [column][row], each pixel packed as {red, green, blue}.
  typedef struct packed {
    logic [2:0][2:0][23:0] px;
    logic                  top_out;
    logic                  bot_out;
    logic                  left_out;
    logic                  right_out;
    logic                  done;
  } sem_job_t;

endpackage

`default_nettype wire

### hw/rtl/sem_ram.sv
`default_nettype none

module sem_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### hw/rtl/sem_fifo.sv
`default_nettype none

module sem_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      count_r <= count_r + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sem_front.sv
`default_nettype none

module sem_front
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [11:0] cfg_width,
  input  logic [15:0] cfg_height,
  input  logic        in_push,
  input  sem_in_t     in_data,
  output logic        in_full,
  output logic        job_push,
  output sem_job_t    job_data,
  input  logic        job_full
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WEW = $clog2(MAX_WIDTH + 1);
  localparam int EW  = (WEW > 12) ? WEW : 12;

  logic [EW-1:0]         wcfg;
  logic [WEW-1:0]        w;
  logic [15:0]           h;
  logic                  busy_r;
  logic [23:0]           pix_r;
  logic [CW-1:0]         col_r, col_nxt;
  logic [16:0]           row_r, row_nxt;
  logic                  drain_r;
  logic [2:0][2:0][23:0] win_r, win_nxt;
  logic [23:0]           top_rd, mid_rd;
  logic                  take, emit0, emit1, wrap;
  logic [15:0]           orow;
  logic [CW-1:0]         ocol, wlast;
  logic [WEW-1:0]        col_inc;

  assign wcfg = EW'(cfg_width);

  always_comb begin
    if (wcfg == '0) begin
      w = WEW'(1);
    end else if (wcfg > EW'(MAX_WIDTH)) begin
      w = WEW'(MAX_WIDTH);
    end else begin
      w = WEW'(wcfg);
    end
  end

  assign h = (cfg_height == '0) ? 16'd1 : cfg_height;

  assign in_full = busy_r || job_full;
  assign take    = in_push && !in_full && (drain_r || (in_data.req_type == REQ_PIXEL));

  sem_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (busy_r),
    .waddr (col_r),
    .wdata (mid_rd),
    .raddr (col_r),
    .rdata (top_rd)
  );

  sem_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (busy_r),
    .waddr (col_r),
    .wdata (pix_r),
    .raddr (col_r),
    .rdata (mid_rd)
  );

  always_comb begin
    win_nxt[0]    = win_r[1];
    win_nxt[1]    = win_r[2];
    win_nxt[2][0] = top_rd;
    win_nxt[2][1] = mid_rd;
    win_nxt[2][2] = pix_r;

    emit0 = (col_r == '0) && (row_r >= 17'd2);
    emit1 = (col_r != '0) && (row_r != '0);
    wlast = CW'(w - WEW'(1));
    orow  = emit0 ? 16'(row_r - 17'd2) : 16'(row_r - 17'd1);
    ocol  = emit0 ? wlast : col_r - CW'(1);

    job_data.px[0]    = emit0 ? win_r[1] : win_nxt[0];
    job_data.px[1]    = emit0 ? win_r[2] : win_nxt[1];
    job_data.px[2]    = emit0 ? '0 : win_nxt[2];
    job_data.top_out  = (orow == '0);
    job_data.bot_out  = (orow >= h - 16'd1);
    job_data.left_out = (ocol == '0);
    job_data.right_out = (ocol >= wlast);
    job_data.done     = job_data.bot_out && job_data.right_out;

    col_inc = WEW'(col_r) + WEW'(1);
    wrap    = (col_inc >= w);
    col_nxt = wrap ? '0 : CW'(col_inc);
    row_nxt = row_r + 17'(wrap);
  end

  assign job_push = busy_r && (emit0 || emit1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      col_r   <= '0;
      row_r   <= '0;
      drain_r <= 1'b0;
      win_r   <= '0;
    end else begin
      busy_r <= take;
      if (busy_r) begin
        win_r <= win_nxt;
        if (job_push && job_data.done) begin
          col_r   <= '0;
          row_r   <= '0;
          drain_r <= 1'b0;
        end else begin
          col_r <= col_nxt;
          row_r <= row_nxt;
          if (row_nxt >= {1'b0, h}) begin
            drain_r <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pix_r <= drain_r ? 24'd0 : {in_data.in_red, in_data.in_green, in_data.in_blue};
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sem_back.sv
`default_nettype none

module sem_back
  import sem_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     job_empty,
  input  sem_job_t job_data,
  output logic     job_pop,
  input  logic     res_full,
  output logic     res_push,
  output sem_out_t res_data
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_SQ   = 2'd1;
  localparam logic [1:0] B_ROOT = 2'd2;
  localparam logic [1:0] B_RND  = 2'd3;

  logic [1:0]         state_r;
  logic [2:0]         step_r;
  logic               done_r;
  logic signed [10:0] gx_c [3];
  logic signed [10:0] gy_c [3];
  logic signed [10:0] gx_r [3];
  logic signed [10:0] gy_r [3];
  logic signed [21:0] pgx [3];
  logic signed [21:0] pgy [3];
  logic [20:0]        sq_c [3];
  logic [15:0]        s_r [3];
  logic               sat_r [3];
  logic [7:0]         root_r [3];
  logic [7:0]         root_c [3];
  logic [7:0]         fin_c [3];
  logic [7:0]         trial [3];
  logic [15:0]        tsq [3];
  logic [15:0]        rsq [3];
  logic [15:0]        rem [3];

  always_comb begin
    logic signed [10:0] vv [3][3];
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 3; k++) begin
        for (int t = 0; t < 3; t++) begin
          if ((t == 0 && job_data.top_out) || (t == 2 && job_data.bot_out) ||
              (k == 0 && job_data.left_out) || (k == 2 && job_data.right_out)) begin
            vv[k][t] = '0;
          end else begin
            vv[k][t] = $signed({3'b000, job_data.px[k][t][8*ch +: 8]});
          end
        end
      end
      gx_c[ch] = vv[2][0] - vv[0][0] + 11'sd2 * (vv[2][1] - vv[0][1]) + vv[2][2] - vv[0][2];
      gy_c[ch] = vv[0][2] + 11'sd2 * vv[1][2] + vv[2][2]
               - vv[0][0] - 11'sd2 * vv[1][0] - vv[2][0];
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      pgx[ch]    = gx_r[ch] * gx_r[ch];
      pgy[ch]    = gy_r[ch] * gy_r[ch];
      sq_c[ch]   = 21'(pgx[ch]) + 21'(pgy[ch]);
      trial[ch]  = root_r[ch] | (8'd1 << step_r);
      tsq[ch]    = trial[ch] * trial[ch];
      root_c[ch] = (tsq[ch] <= s_r[ch]) ? trial[ch] : root_r[ch];
      rsq[ch]    = root_r[ch] * root_r[ch];
      rem[ch]    = s_r[ch] - rsq[ch];
      if (sat_r[ch]) begin
        fin_c[ch] = EDGE_MAX;
      end else if (rem[ch] > {8'd0, root_r[ch]}) begin
        fin_c[ch] = root_r[ch] + 8'd1;
      end else begin
        fin_c[ch] = root_r[ch];
      end
    end
  end

  assign job_pop  = (state_r == B_IDLE) && !job_empty;
  assign res_push = (state_r == B_RND) && !res_full;

  assign res_data.edge_blue  = fin_c[0];
  assign res_data.edge_green = fin_c[1];
  assign res_data.edge_red   = fin_c[2];
  assign res_data.image_done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      step_r  <= '0;
    end else begin
      unique case (state_r)
        B_IDLE: begin
          if (job_pop) begin
            state_r <= B_SQ;
          end
        end
        B_SQ: begin
          state_r <= B_ROOT;
          step_r  <= 3'd7;
        end
        B_ROOT: begin
          if (step_r == '0) begin
            state_r <= B_RND;
          end else begin
            step_r <= step_r - 3'd1;
          end
        end
        B_RND: begin
          if (res_push) begin
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      if (job_pop) begin
        gx_r[ch] <= gx_c[ch];
        gy_r[ch] <= gy_c[ch];
      end
      if (state_r == B_SQ) begin
        s_r[ch]    <= sq_c[ch][15:0];
        sat_r[ch]  <= (sq_c[ch] > SAT_LIMIT);
        root_r[ch] <= '0;
      end else if (state_r == B_ROOT) begin
        root_r[ch] <= root_c[ch];
      end
    end
    if (job_pop) begin
      done_r <= job_data.done;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sobel_edge_magnitude_rgb_core.sv
`default_nettype none

// Streaming 3x3 Sobel edge magnitude on RGB pixels in raster order. Each pixel
// transaction does a row store read, then a window update in the front end, so
// in_full is high for one cycle after every accepted pixel or drain transaction
// and while the job queue is full; a flush before the image end is accepted and
// dropped. In the back end each result passes through gradients, squares, eight
// steps of the bit-serial square root and rounding; a new job is taken only once
// the result is pushed, which waits while the result queue is full. The
// result for a pixel appears once its lower-right neighbour has arrived; after
// the last pixel, image_width + 1 flush transactions drain the rest, the last
// one carrying image_done. The row stores need no clearing pass after reset.
module sobel_edge_magnitude_rgb_core
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  sem_in_t  in_data,
  output logic     in_full,
  output logic     out_empty,
  input  logic     out_pop,
  output sem_out_t out_data,
  input  logic     cfg_we,
  input  logic     cfg_index,
  input  logic [15:0] cfg_data
);

  logic [11:0] width_r;
  logic [15:0] height_r;
  logic        job_push, job_full, job_pop, job_empty;
  sem_job_t    job_wr, job_rd;
  logic        res_push, res_full;
  sem_out_t    res_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH_IDX:  width_r  <= cfg_data[11:0];
        CFG_HEIGHT_IDX: height_r <= cfg_data;
      endcase
    end
  end

  sem_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_width  (width_r),
    .cfg_height (height_r),
    .in_push    (in_push),
    .in_data    (in_data),
    .in_full    (in_full),
    .job_push   (job_push),
    .job_data   (job_wr),
    .job_full   (job_full)
  );

  sem_fifo #(.WIDTH($bits(sem_job_t)), .DEPTH(2)) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata (job_wr),
    .full  (job_full),
    .pop   (job_pop),
    .empty (job_empty),
    .rdata (job_rd)
  );

  sem_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job_data  (job_rd),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  sem_fifo #(.WIDTH($bits(sem_out_t)), .DEPTH(2)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (out_pop),
    .empty (out_empty),
    .rdata (out_data)
  );

endmodule

`default_nettype wire

### hw/rtl/sem_checker.sv
`default_nettype none

module sem_checker
  import sem_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_push,
  input sem_in_t  in_data,
  input logic     in_full,
  input logic     out_empty,
  input logic     out_pop,
  input sem_out_t out_data
);

  // Reset flushes every pending result.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // A pixel transaction occupies the front end for its row store read.
  a_pixel_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full && in_data.req_type == REQ_PIXEL) |=> in_full)
    else $error("input not held off after pixel transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("waiting result changed or vanished");

endmodule

bind sobel_edge_magnitude_rgb_core sem_checker u_sem_checker (.*);

`default_nettype wire
